### rtl/mmcrc_pkg.sv
// ============================================================================
// mmcrc_pkg - shared definitions for the multi-mode CRC engine
// Mode codes, polynomials, init values, register map and the unrolled
// per-byte / per-word CRC update functions.
// ============================================================================
`default_nettype none

package mmcrc_pkg;

    // Widths of the item fields and of the register port
    localparam int DataWidth  = 8;
    localparam int CrcWidth   = 32;
    localparam int BufWidth   = 24;
    localparam int CountWidth = 2;
    localparam int ModeWidth  = 2;
    localparam int AddrWidth  = 3;
    localparam int PdataWidth = 32;

    // Mode codes
    localparam logic [ModeWidth-1:0] MODE_CRC8  = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_CRC16 = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_CRC32 = 2'd2;
    localparam logic [ModeWidth-1:0] MODE_RSVD  = 2'd3;

    // Register index of crc_mode (byte address 4 * index)
    localparam logic [AddrWidth-3:0] REG_CRC_MODE = 1'b0;

    // Polynomials
    localparam logic [7:0]  POLY8  = 8'h8C;
    localparam logic [15:0] POLY16 = 16'h1021;
    localparam logic [31:0] POLY32 = 32'h04C1_1DB7;

    // Init values
    localparam logic [31:0] INIT8  = 32'h0000_00FF;
    localparam logic [31:0] INIT16 = 32'h0000_FFFF;
    localparam logic [31:0] INIT32 = 32'hFFFF_FFFF;

    // Last word slot of the little-endian packer
    localparam logic [CountWidth-1:0] LAST_SLOT = 2'd3;

    // Init value of the CRC register for a given mode
    function automatic logic [CrcWidth-1:0] mode_init(input logic [ModeWidth-1:0] mode);
        logic [CrcWidth-1:0] v;
        case (mode)
            MODE_CRC8:  v = INIT8;
            MODE_CRC16: v = INIT16;
            default:    v = INIT32;
        endcase
        return v;
    endfunction

    // Reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ POLY8;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // MSB-first CRC-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c  = c << 1;
            if (fb)
                c = c ^ POLY16;
        end
        return c;
    endfunction

    // MSB-first CRC-32, one 32-bit word
    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 31; k >= 0; k--) begin
            fb = c[31] ^ word[k];
            c  = c << 1;
            if (fb)
                c = c ^ POLY32;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/mmcrc_if.sv
// ============================================================================
// mmcrc_in_if / mmcrc_out_if - valid/ready channels of the CRC engine
// Message byte channel and CRC result channel.
// ============================================================================
`default_nettype none

interface mmcrc_in_if;
    logic                           valid;
    logic                           ready;
    logic [mmcrc_pkg::DataWidth-1:0] data_byte;
    logic                           first_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface mmcrc_out_if;
    logic                           valid;
    logic                           ready;
    logic [mmcrc_pkg::CrcWidth-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

### rtl/multi_mode_crc_engine.sv
// ============================================================================
// multi_mode_crc_engine - byte-wide CRC-8 / CRC-16 / CRC-32 engine
// Folds one message byte per cycle, unless msg.ready is low, into the CRC
// register and emits the CRC on the last byte. CRC-32 words are little-endian.
// ============================================================================
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  ----------------------------------------
//  msg      in   valid / ready   data_byte[7:0], first_byte, last_byte
//  result   out  valid / ready   crc_value[31:0]
//  apb      in   psel / penable  paddr[2:0], pwdata[31:0] -> crc_mode
//
//  One byte is accepted every cycle while msg.ready is high; the CRC
//  update is a single unrolled XOR network between the input handshake
//  and the state registers. A message's CRC is registered into the output
//  register, or into the one skid entry behind it while the output is held;
//  msg.ready drops only while two results are waiting.
//  Reset (rst_n low, asynchronous) sets mode CRC-8, CRC all ones, buffer empty.
// ============================================================================
`default_nettype none

module multi_mode_crc_engine
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mmcrc_in_if.sink                               msg,
    mmcrc_out_if.source                            result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mmcrc_pkg::AddrWidth-1:0]   paddr,
    input  wire logic [mmcrc_pkg::PdataWidth-1:0]  pwdata,
    output logic      [mmcrc_pkg::PdataWidth-1:0]  prdata,
    output logic                                   pready
);
    import mmcrc_pkg::*;

    // State
    logic [ModeWidth-1:0]  mode_reg;
    logic [CrcWidth-1:0]   crc_reg,   crc_next;
    logic [BufWidth-1:0]   buf_reg,   buf_next;
    logic [CountWidth-1:0] cnt_reg,   cnt_next;

    // Output register and skid entry
    logic                  out_valid_reg;
    logic [CrcWidth-1:0]   out_data_reg;
    logic                  skid_valid_reg;
    logic [CrcWidth-1:0]   skid_data_reg;

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  cfg_write;
    logic                  reg_sel;

    logic [CrcWidth-1:0]   crc_cur;
    logic [BufWidth-1:0]   buf_cur;
    logic [CountWidth-1:0] cnt_cur;
    logic [CrcWidth-1:0]   word;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[AddrWidth-1:2] == REG_CRC_MODE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_sel ? {{(PdataWidth-ModeWidth){1'b0}}, mode_reg}
                               : {PdataWidth{1'b0}};

    // reserved mode code is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CRC8;
        end
        else if (cfg_write && reg_sel && (pwdata[ModeWidth-1:0] != MODE_RSVD))
        begin
            mode_reg <= pwdata[ModeWidth-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign msg.ready     = !skid_valid_reg;
    assign accept        = msg.valid && msg.ready;
    assign push          = accept && msg.last_byte;
    assign pop           = out_valid_reg && result.ready;
    assign result.valid     = out_valid_reg;
    assign result.crc_value = out_data_reg;

    // ------------------------------------------------------------------
    // CRC update for one byte
    // ------------------------------------------------------------------
    always_comb
    begin
        // first byte restarts from the mode's init value
        crc_cur = msg.first_byte ? mode_init(mode_reg) : crc_reg;
        buf_cur = msg.first_byte ? {BufWidth{1'b0}} : buf_reg;
        cnt_cur = msg.first_byte ? {CountWidth{1'b0}} : cnt_reg;

        // little-endian word with this byte in its slot
        word = {{(CrcWidth-BufWidth){1'b0}}, buf_cur}
             | ({{(CrcWidth-DataWidth){1'b0}}, msg.data_byte} << {cnt_cur, 3'b000});

        crc_next = crc_cur;
        buf_next = buf_cur;
        cnt_next = cnt_cur;

        case (mode_reg)
            MODE_CRC8:
            begin
                crc_next = {{(CrcWidth-8){1'b0}}, crc8_byte(crc_cur[7:0], msg.data_byte)};
            end
            MODE_CRC16:
            begin
                crc_next = {{(CrcWidth-16){1'b0}}, crc16_byte(crc_cur[15:0], msg.data_byte)};
            end
            default:
            begin
                // full word, or padded partial word on the last byte
                if ((cnt_cur == LAST_SLOT) || msg.last_byte)
                begin
                    crc_next = crc32_word(crc_cur, word);
                    buf_next = {BufWidth{1'b0}};
                    cnt_next = {CountWidth{1'b0}};
                end
                else
                begin
                    buf_next = word[BufWidth-1:0];
                    cnt_next = cnt_cur + 1'b1;
                end
            end
        endcase

        // last byte empties the packer in every mode
        if (msg.last_byte)
        begin
            buf_next = {BufWidth{1'b0}};
            cnt_next = {CountWidth{1'b0}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= INIT32;
            buf_reg <= {BufWidth{1'b0}};
            cnt_reg <= {CountWidth{1'b0}};
        end
        else if (accept)
        begin
            crc_reg <= crc_next;
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= crc_next;
            end
            else
            begin
                out_data_reg <= crc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while output register is empty");

    a_last_empties_buf: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && msg.last_byte) |=> (cnt_reg == '0) && (buf_reg == '0))
        else $error("word buffer not emptied after last byte");

    a_crc8_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_CRC8)) |=> (crc_reg[CrcWidth-1:8] == '0))
        else $error("CRC-8 update left upper CRC bits set");

endmodule

`default_nettype wire
